FILE: rtl/core/fhc_pkg.sv
// ----------------------------------------------------------------------------
// fhc_pkg: shared types and constants of the frame header checker
// Field positions of the header, payload limit, status codes and register
// indexes.
// ----------------------------------------------------------------------------
package fhc_pkg;

  // Counter and field widths
  localparam int unsigned CountW   = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Byte positions at which each header field ends
  localparam logic [CountW-1:0] PosMagicEnd = 32'd4;
  localparam logic [CountW-1:0] PosMajorEnd = 32'd6;
  localparam logic [CountW-1:0] PosMinorEnd = 32'd8;
  localparam logic [CountW-1:0] PosKindEnd  = 32'd10;
  localparam logic [CountW-1:0] PosFlagsEnd = 32'd12;
  localparam logic [CountW-1:0] PosTagEnd   = 32'd20;
  localparam logic [CountW-1:0] HeaderBytes = 32'd24;

  // Largest payload length accepted, and the saturation value of the count
  localparam logic [CountW-1:0] MaxPayload = 32'd65536;
  localparam logic [CountW-1:0] CountMax   = '1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgMagicWord       = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgVersionMajor    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgVersionMinorMax = 2'd2;

  // Reset values of the configuration registers
  localparam logic [31:0] MagicWordRst       = 32'd0;
  localparam logic [15:0] VersionMajorRst    = 16'd1;
  localparam logic [15:0] VersionMinorMaxRst = 16'd0;

  // Frame verdict
  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StTooSmall  = 3'd1,
    StBadMagic  = 3'd2,
    StVersion   = 3'd3,
    StFlags     = 3'd4,
    StTooLarge  = 3'd5,
    StMismatch  = 3'd6
  } status_e;

endpackage

FILE: rtl/core/fhc_if.sv
// ----------------------------------------------------------------------------
// fhc_if: channel interfaces of the frame header checker
// Byte input channel, result channel and configuration write channel, each
// with valid/ready handshake.
// ----------------------------------------------------------------------------

// Frame bytes in
interface fhc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Payload bytes and frame verdicts out
interface fhc_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic        frame_done;
  logic [2:0]  status;
  logic [15:0] got_major;
  logic [15:0] got_minor;
  logic [15:0] message_kind;
  logic [63:0] request_tag;
  logic [31:0] payload_length;

  modport source (
    output valid, output payload_valid, output payload_byte, output frame_done,
    output status, output got_major, output got_minor, output message_kind,
    output request_tag, output payload_length, input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_byte, input frame_done,
    input status, input got_major, input got_minor, input message_kind,
    input request_tag, input payload_length, output ready
  );
endinterface

// Configuration register writes
interface fhc_cfg_if
  import fhc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/frame_header_checker.sv
// ----------------------------------------------------------------------------
// frame_header_checker: byte-stream frame header capture and check
// Captures the 24-byte big-endian header, forwards payload bytes while the
// header passes, and closes each frame with the header fields and a status.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle while the output register is free: a byte is
// registered on transfer, then shifted into the header fields, counted and
// checked when the byte stage advances, and its result (if any) is loaded
// into the output register. The sustained rate is set by the output register:
// while a result waits untaken, the byte stage holds and input ready drops
// once it is also full. A byte gives a result when it is a forwarded payload
// byte or carries the last-byte mark; other bytes give none. Configuration
// writes are always taken and apply to every byte checked after them; status
// codes are 0 ok, 1 too small, 2 bad magic, 3 version, 4 flags, 5 too large,
// 6 size mismatch, the first that applies winning.
module frame_header_checker
  import fhc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  fhc_cfg_if.sink      cfg_i,
  fhc_in_if.sink       in_i,
  fhc_out_if.source    out_o
);

  // Configuration registers
  logic [31:0] magic_word_q;
  logic [15:0] version_major_q;
  logic [15:0] version_minor_max_q;

  // Byte stage
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // Frame state
  logic [CountW-1:0] byte_count_q, byte_count_d;
  logic [31:0]       magic_q, magic_d;
  logic [15:0]       major_q, major_d;
  logic [15:0]       minor_q, minor_d;
  logic [15:0]       kind_q, kind_d;
  logic [15:0]       flags_q, flags_d;
  logic [63:0]       tag_q, tag_d;
  logic [31:0]       length_q, length_d;

  // Output register
  logic        out_valid_q;
  logic        out_pl_valid_q;
  logic [7:0]  out_pl_byte_q;
  logic        out_done_q;
  status_e     out_status_q;
  logic [15:0] out_major_q;
  logic [15:0] out_minor_q;
  logic [15:0] out_kind_q;
  logic [63:0] out_tag_q;
  logic [31:0] out_length_q;

  logic    out_free;
  logic    step;
  logic    fwd;
  logic    emit;
  status_e verdict;
  status_e status_d;
  logic    is_header;

  // Accept configuration writes at any time
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_word_q        <= MagicWordRst;
      version_major_q     <= VersionMajorRst;
      version_minor_max_q <= VersionMinorMaxRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgMagicWord:       magic_word_q        <= cfg_i.data;
        CfgVersionMajor:    version_major_q     <= cfg_i.data[15:0];
        CfgVersionMinorMax: version_minor_max_q <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  // Handshake: the byte stage advances whenever the output register can load
  assign out_free   = !out_valid_q || out_o.ready;
  assign step       = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.last_byte;
    end
  end

  // Shift the byte into the field its position selects
  always_comb begin
    magic_d   = magic_q;
    major_d   = major_q;
    minor_d   = minor_q;
    kind_d    = kind_q;
    flags_d   = flags_q;
    tag_d     = tag_q;
    length_d  = length_q;
    is_header = 1'b1;
    if (byte_count_q < PosMagicEnd) begin
      magic_d = {magic_q[23:0], s1_byte_q};
    end else if (byte_count_q < PosMajorEnd) begin
      major_d = {major_q[7:0], s1_byte_q};
    end else if (byte_count_q < PosMinorEnd) begin
      minor_d = {minor_q[7:0], s1_byte_q};
    end else if (byte_count_q < PosKindEnd) begin
      kind_d = {kind_q[7:0], s1_byte_q};
    end else if (byte_count_q < PosFlagsEnd) begin
      flags_d = {flags_q[7:0], s1_byte_q};
    end else if (byte_count_q < PosTagEnd) begin
      tag_d = {tag_q[55:0], s1_byte_q};
    end else if (byte_count_q < HeaderBytes) begin
      length_d = {length_q[23:0], s1_byte_q};
    end else begin
      is_header = 1'b0;
    end
  end

  // Count bytes, holding at the top value
  assign byte_count_d = (byte_count_q == CountMax) ? byte_count_q : byte_count_q + 1'b1;

  // Header checks on the updated fields, size excluded
  always_comb begin
    if (magic_d != magic_word_q) begin
      verdict = StBadMagic;
    end else if (major_d != version_major_q || minor_d > version_minor_max_q) begin
      verdict = StVersion;
    end else if (flags_d != '0) begin
      verdict = StFlags;
    end else if (length_d > MaxPayload) begin
      verdict = StTooLarge;
    end else begin
      verdict = StOk;
    end
  end

  // Final status of a frame closing on this byte
  always_comb begin
    if (byte_count_d < HeaderBytes) begin
      status_d = StTooSmall;
    end else if (verdict != StOk) begin
      status_d = verdict;
    end else if ({1'b0, byte_count_d} != {1'b0, HeaderBytes} + {1'b0, length_d}) begin
      status_d = StMismatch;
    end else begin
      status_d = StOk;
    end
  end

  assign fwd  = !is_header && (verdict == StOk);
  assign emit = step && (fwd || s1_last_q);

  // Advance the frame state; clear it when the frame closes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      magic_q      <= '0;
      major_q      <= '0;
      minor_q      <= '0;
      kind_q       <= '0;
      flags_q      <= '0;
      tag_q        <= '0;
      length_q     <= '0;
    end else if (step) begin
      if (s1_last_q) begin
        byte_count_q <= '0;
        magic_q      <= '0;
        major_q      <= '0;
        minor_q      <= '0;
        kind_q       <= '0;
        flags_q      <= '0;
        tag_q        <= '0;
        length_q     <= '0;
      end else begin
        byte_count_q <= byte_count_d;
        magic_q      <= magic_d;
        major_q      <= major_d;
        minor_q      <= minor_d;
        kind_q       <= kind_d;
        flags_q      <= flags_d;
        tag_q        <= tag_d;
        length_q     <= length_d;
      end
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit;
    end
  end

  // Output register: payload; header fields read zero unless the frame closes
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_pl_valid_q <= fwd;
      out_pl_byte_q  <= fwd ? s1_byte_q : 8'd0;
      out_done_q     <= s1_last_q;
      out_status_q   <= s1_last_q ? status_d : StOk;
      out_major_q    <= s1_last_q ? major_d  : 16'd0;
      out_minor_q    <= s1_last_q ? minor_d  : 16'd0;
      out_kind_q     <= s1_last_q ? kind_d   : 16'd0;
      out_tag_q      <= s1_last_q ? tag_d    : 64'd0;
      out_length_q   <= s1_last_q ? length_d : 32'd0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.payload_valid  = out_pl_valid_q;
  assign out_o.payload_byte   = out_pl_byte_q;
  assign out_o.frame_done     = out_done_q;
  assign out_o.status         = out_status_q;
  assign out_o.got_major      = out_major_q;
  assign out_o.got_minor      = out_minor_q;
  assign out_o.message_kind   = out_kind_q;
  assign out_o.request_tag    = out_tag_q;
  assign out_o.payload_length = out_length_q;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the frame header checker
// Streams frames of bytes through the block, predicts every payload byte and
// frame verdict from its own copy of the header state, and checks each output
// transfer in order. Directed frames cover short frames, each header check,
// register extremes and a long output stall; random traffic follows.
// ----------------------------------------------------------------------------
module tb;
  import fhc_pkg::*;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_done;
    status_e     status;
    logic [15:0] got_major;
    logic [15:0] got_minor;
    logic [15:0] message_kind;
    logic [63:0] request_tag;
    logic [31:0] payload_length;
  } frame_result_t;

  logic clk_i;
  logic rst_ni;

  fhc_cfg_if cfg_if ();
  fhc_in_if  byte_if ();
  fhc_out_if res_if ();

  frame_header_checker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (byte_if),
    .out_o  (res_if)
  );

  // Predicted configuration and header capture state
  logic [31:0]       cfg_magic;
  logic [15:0]       cfg_major;
  logic [15:0]       cfg_minor_max;
  logic [CountW-1:0] seen_count;
  logic [31:0]       magic_acc;
  logic [15:0]       major_acc;
  logic [15:0]       minor_acc;
  logic [15:0]       kind_acc;
  logic [15:0]       flags_acc;
  logic [63:0]       tag_acc;
  logic [31:0]       length_acc;

  frame_result_t pending_results[$];

  int errors;
  int bytes_sent;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_serial;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Header checks other than size, in priority order
  function automatic status_e header_status();
    if (magic_acc != cfg_magic) return StBadMagic;
    if (major_acc != cfg_major || minor_acc > cfg_minor_max) return StVersion;
    if (flags_acc != 16'h0) return StFlags;
    if (length_acc > MaxPayload) return StTooLarge;
    return StOk;
  endfunction

  // Shift one byte into the header state and queue the result it causes
  function automatic void predict_frame_byte(input logic [7:0] b, input logic is_last);
    frame_result_t     res;
    logic              fwd;
    logic [CountW-1:0] pos;
    pos = seen_count;
    fwd = 1'b0;
    if (pos < PosMagicEnd) magic_acc = {magic_acc[23:0], b};
    else if (pos < PosMajorEnd) major_acc = {major_acc[7:0], b};
    else if (pos < PosMinorEnd) minor_acc = {minor_acc[7:0], b};
    else if (pos < PosKindEnd) kind_acc = {kind_acc[7:0], b};
    else if (pos < PosFlagsEnd) flags_acc = {flags_acc[7:0], b};
    else if (pos < PosTagEnd) tag_acc = {tag_acc[55:0], b};
    else if (pos < HeaderBytes) length_acc = {length_acc[23:0], b};
    else fwd = (header_status() == StOk);
    // the count saturates rather than wrapping
    if (seen_count != CountMax) seen_count = seen_count + 1'b1;
    if (!(fwd || is_last)) return;

    res = '0;
    if (fwd) begin
      res.payload_valid = 1'b1;
      res.payload_byte  = b;
    end
    if (is_last) begin
      res.frame_done = 1'b1;
      if (seen_count < HeaderBytes) begin
        res.status = StTooSmall;
      end else begin
        res.status = header_status();
        if (res.status == StOk &&
            {1'b0, seen_count} != {1'b0, HeaderBytes} + {1'b0, length_acc}) begin
          res.status = StMismatch;
        end
      end
      res.got_major      = major_acc;
      res.got_minor      = minor_acc;
      res.message_kind   = kind_acc;
      res.request_tag    = tag_acc;
      res.payload_length = length_acc;
      // start the next frame from a clean state
      seen_count = '0;
      magic_acc  = '0;
      major_acc  = '0;
      minor_acc  = '0;
      kind_acc   = '0;
      flags_acc  = '0;
      tag_acc    = '0;
      length_acc = '0;
    end
    pending_results.insert(pending_results.size(), res);
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want_v,
                                      input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  function automatic logic [191:0] make_header(
    input logic [31:0] magic, input logic [15:0] major, input logic [15:0] minor,
    input logic [15:0] kind, input logic [15:0] flags, input logic [63:0] tag,
    input logic [31:0] len
  );
    return {magic, major, minor, kind, flags, tag, len};
  endfunction

  // Offer one byte, idling at random first, and hold it until the transfer
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    while ($urandom_range(99) < tx_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= value;
    byte_if.last_byte <= is_last;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    predict_frame_byte(value, is_last);
    bytes_sent++;
  endtask

  // Header bytes first, then random payload; the final byte carries the mark
  task automatic send_frame(input logic [191:0] header, input int unsigned n_bytes);
    logic [7:0] b;
    for (int unsigned i = 0; i < n_bytes; i++) begin
      b = (i < 24) ? header[191 - 8 * i -: 8] : 8'($urandom);
      send_byte(b, i == n_bytes - 1);
    end
  endtask

  // Drop input valid and let every outstanding result drain
  task automatic settle_block();
    int n;
    byte_if.valid <= 1'b0;
    for (n = 0; pending_results.size() != 0 && n < 20000; n++) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      errors++;
      pending_results.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Write one register once the block is idle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
    settle_block();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      CfgMagicWord:       cfg_magic = value;
      CfgVersionMajor:    cfg_major = value[15:0];
      CfgVersionMinorMax: cfg_minor_max = value[15:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  // Receiver ready: random idling, or a long hold when one is requested
  initial begin : result_ready
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_serial) begin
        hold_seen = hold_serial;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Compare each output transfer with the oldest expectation
  always @(posedge clk_i) begin : result_check
    frame_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual payload_valid=%0b frame_done=%0b",
                 $time, res_if.payload_valid, res_if.frame_done);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("payload_valid", 64'(want.payload_valid), 64'(res_if.payload_valid));
        check_field("payload_byte", 64'(want.payload_byte), 64'(res_if.payload_byte));
        check_field("frame_done", 64'(want.frame_done), 64'(res_if.frame_done));
        check_field("status", 64'(want.status), 64'(res_if.status));
        check_field("got_major", 64'(want.got_major), 64'(res_if.got_major));
        check_field("got_minor", 64'(want.got_minor), 64'(res_if.got_minor));
        check_field("message_kind", 64'(want.message_kind), 64'(res_if.message_kind));
        check_field("request_tag", want.request_tag, res_if.request_tag);
        check_field("payload_length", 64'(want.payload_length),
                    64'(res_if.payload_length));
      end
    end
  end

  // Frames that end inside the header
  task automatic test_short_frames();
    send_frame(make_header('1, '1, '1, '1, '1, '1, '1), 1);
    send_frame(make_header($urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), {$urandom, $urandom}, $urandom), 23);
  endtask

  // Each header check under the reset configuration, and its priority
  task automatic test_header_checks();
    send_frame(make_header(32'h0, 16'h1, 16'h0, 16'h0, 16'h0, 64'h0, 32'd0), 24);
    send_frame(make_header(32'h0, 16'h1, 16'h0, 16'h1234, 16'h0, {$urandom, $urandom},
                           32'd3), 27);
    send_frame(make_header(32'h1, 16'h1, 16'h0, 16'h0, 16'h0, 64'h0, 32'd2), 26);
    send_frame(make_header(32'h1, 16'h2, 16'h5, 16'h0, 16'h1, 64'h0, 32'd2), 26);
    send_frame(make_header(32'h0, 16'h2, 16'h0, 16'h0, 16'h0, 64'h0, 32'd2), 26);
    send_frame(make_header(32'h0, 16'h1, 16'h1, 16'h0, 16'h0, 64'h0, 32'd2), 26);
    send_frame(make_header(32'h0, 16'h1, 16'h0, 16'h0, 16'h8000, 64'h0, 32'd2), 26);
    send_frame(make_header(32'h0, 16'h1, 16'h0, 16'h0, 16'h0, 64'h0, MaxPayload + 1), 26);
    // passes every header check, so bytes flow until the size check at the end
    send_frame(make_header(32'h0, 16'h1, 16'h0, 16'h0, 16'h0, 64'h0, MaxPayload), 26);
    send_frame(make_header(32'h0, 16'h1, 16'h0, 16'h0, 16'h0, 64'h0, 32'd2), 29);
    send_frame(make_header(32'h0, 16'h1, 16'h0, 16'h0, 16'h0, 64'h0, 32'd4), 26);
  endtask

  // Register extremes, all-ones then all-zeros
  task automatic test_register_extremes();
    write_reg(CfgMagicWord, 32'hFFFF_FFFF);
    write_reg(CfgVersionMajor, 32'hFFFF_FFFF);
    write_reg(CfgVersionMinorMax, 32'h0000_FFFF);
    send_frame(make_header('1, '1, '1, '1, 16'h0, '1, 32'd1), 25);
    send_frame(make_header('1, '1, '1, '1, '1, '1, 32'd1), 25);
    write_reg(CfgMagicWord, 32'h0);
    write_reg(CfgVersionMajor, 32'h0);
    write_reg(CfgVersionMinorMax, 32'h0);
    send_frame(make_header(32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 64'h0, 32'd0), 24);
    send_frame(make_header(32'h0, 16'h0, 16'h1, 16'h0, 16'h0, 64'h0, 32'd0), 24);
  endtask

  // Hold the receiver off while a long good frame keeps the input busy
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(CfgMagicWord, 32'hA5C3_5A3C);
    write_reg(CfgVersionMajor, 32'h0000_0003);
    write_reg(CfgVersionMinorMax, 32'h0000_0007);
    hold_serial <= hold_serial + 1;
    send_frame(make_header(32'hA5C3_5A3C, 16'h3, 16'h7, 16'h22, 16'h0,
                           {$urandom, $urandom}, 32'd40), 64);
  endtask

  // Mostly well-formed frames with random content, some broken ones, noise and register writes
  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
    int               target;
    int unsigned      pick;
    int unsigned      n;
    logic [31:0]      len;
    logic [31:0]      value;
    logic [CfgIdxW-1:0] idx;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 7) begin
        // reconfigure between frames, extremes included
        idx   = CfgIdxW'($urandom_range(2));
        pick  = $urandom_range(99);
        value = (pick < 15) ? 32'h0 : (pick < 30) ? 32'hFFFF_FFFF : $urandom;
        if (idx == CfgVersionMajor && pick >= 30 && pick < 70) value = {16'($urandom), 16'h1};
        write_reg(idx, value);
      end else if (pick < 17) begin
        // broken frame of random bytes
        n = $urandom_range(30, 1);
        for (int unsigned i = 0; i < n; i++) send_byte(8'($urandom), i == n - 1);
      end else begin
        pick = $urandom_range(99);
        if (pick < 80) len = $urandom_range(12, 0);
        else if (pick < 85) len = MaxPayload;
        else if (pick < 90) len = MaxPayload + 1;
        else len = $urandom;
        n = ($urandom_range(99) < 85 && len <= 12) ? 24 + len : $urandom_range(36, 1);
        send_frame(make_header(
          ($urandom_range(99) < 88) ? cfg_magic : $urandom,
          ($urandom_range(99) < 88) ? cfg_major : 16'($urandom),
          ($urandom_range(99) < 88) ? 16'($urandom_range(cfg_minor_max, 0))
                                    : 16'($urandom),
          16'($urandom),
          ($urandom_range(99) < 90) ? 16'h0 : 16'($urandom),
          {$urandom, $urandom},
          len), n);
      end
    end
  endtask

  // Reset, then run each test in turn
  initial begin
    errors        = 0;
    bytes_sent    = 0;
    hold_serial   = 0;
    tx_idle_pct   = 20;
    rx_idle_pct   = 49;
    cfg_magic     = MagicWordRst;
    cfg_major     = VersionMajorRst;
    cfg_minor_max = VersionMinorMaxRst;
    seen_count    = '0;
    magic_acc     = '0;
    major_acc     = '0;
    minor_acc     = '0;
    kind_acc      = '0;
    flags_acc     = '0;
    tag_acc       = '0;
    length_acc    = '0;
    rst_ni            <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= '0;
    cfg_if.data       <= '0;
    byte_if.valid     <= 1'b0;
    byte_if.data_byte <= '0;
    byte_if.last_byte <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_frames();
    test_header_checks();
    test_register_extremes();
    test_output_backpressure();
    test_random_traffic(20, 49, 50);
    test_random_traffic(49, 20, 50);
    test_random_traffic(0, 0, 50);

    settle_block();
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
